// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbn_pkg.sv =====
// types and constants of the go-back-n receiver
`default_nettype none

package gbn_pkg;

  localparam logic [7:0] ACK_TYPE  = 8'd1;
  localparam logic [7:0] NAK_TYPE  = 8'd2;
  localparam logic [7:0] FIN_TYPE  = 8'd8;
  localparam logic [7:0] LAST_TYPE = 8'd32;
  localparam logic [7:0] DATA_TYPE = 8'd3;

  localparam logic [7:0] INIT_REPLY_SEQ = 8'd255;

  localparam int unsigned HDR_BYTES = 3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] reply_type;
    logic [7:0] reply_seq;
    logic [7:0] reply_check;
    logic       accepted;
    logic       deliver;
    logic       closed;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t data_a;
    result_t data_b;
  } fifo_wr_t;

  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gbn_out_fifo.sv =====
// result queue taking up to two results per cycle and giving one
`default_nettype none

module gbn_out_fifo (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  gbn_pkg::fifo_wr_t             wr_i,
  input  wire                           pop_i,
  output gbn_pkg::result_t              head_o,
  output logic [gbn_pkg::CNT_W-1:0]     count_o
);
  import gbn_pkg::*;

  result_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   wr_ptr_b;
  logic [CNT_W-1:0]   n_push;

  assign wr_ptr_b = wr_ptr_q + PTR_W'(1);
  assign n_push   = CNT_W'(wr_i.push_a) + CNT_W'(wr_i.push_b);
  assign wr_ptr_d = wr_ptr_q + n_push[PTR_W-1:0];
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
  assign count_d  = count_q + n_push - CNT_W'(pop_i);

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.push_a) begin
      mem_q[wr_ptr_q] <= wr_i.data_a;
    end
    if (wr_i.push_b) begin
      mem_q[wr_ptr_b] <= wr_i.data_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/go_back_n_receiver.sv =====
// go-back-n receiver top level
`default_nettype none

// Go-back-N receiver. Takes one packet byte per request (type, sequence,
// length, checksum, then length payload bytes) and returns each payload byte
// at once, followed after the final byte by a verdict carrying the ACK/NAK
// reply. One byte is accepted every cycle unless the input stalls, which
// happens only when the output is held back. The final payload byte of a
// packet yields two results, and the result queue absorbs the extra one while
// the next header bytes arrive. An accepted byte passes through the byte
// register, then the four-entry result queue, before its first result shows.
// After an accepted FIN all further bytes are taken and dropped.
module go_back_n_receiver (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] data_byte_i,
  input  wire        start_of_packet_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] reply_type_o,
  output logic [7:0] reply_seq_o,
  output logic [7:0] reply_check_o,
  output logic       accepted_o,
  output logic       deliver_o,
  output logic       closed_o,
  output logic       last_o
);
  import gbn_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       sop_q;

  // receiver state
  logic [7:0] exp_seq_q, exp_seq_d;
  logic [7:0] prev_type_q, prev_type_d;
  logic [7:0] prev_seq_q, prev_seq_d;
  logic [8:0] pos_q, pos_d;
  logic [7:0] pkt_type_q, pkt_type_d;
  logic [7:0] pkt_seq_q, pkt_seq_d;
  logic [7:0] pay_len_q, pay_len_d;
  logic [7:0] sum_q, sum_d;
  logic       finished_q, finished_d;

  logic       accept;
  logic       proceed;
  logic       work;
  logic [8:0] pos;
  logic       is_payload;
  logic       is_verdict;
  logic       acc;
  logic       fin;
  logic [7:0] v_type;
  logic [7:0] v_seq;
  result_t    pay_res;
  result_t    ver_res;
  fifo_wr_t   wr;
  result_t    head;
  logic [CNT_W-1:0] count;
  logic       pop;

  // room for two results before a byte is processed
  assign proceed    = count <= CNT_W'(FIFO_DEPTH - 2);
  assign in_stall_o = in_valid_q & ~proceed;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_valid_d = accept | (in_valid_q & ~proceed);
  assign work       = in_valid_q & proceed & ~finished_q;

  assign pos        = sop_q ? 9'd0 : pos_q;
  assign sum_d      = (pos == 9'd0) ? byte_q : eac_add(sum_q, byte_q);
  assign is_payload = pos > 9'(HDR_BYTES);
  assign is_verdict = (pos >= 9'(HDR_BYTES)) &&
                      (pos == ({1'b0, pay_len_q} + 9'(HDR_BYTES)));
  assign acc        = (sum_d == 8'hFF) && (pkt_seq_q == exp_seq_q);
  assign fin        = acc && (pkt_type_q == FIN_TYPE);
  assign v_type     = acc ? ACK_TYPE : prev_type_q;
  assign v_seq      = acc ? pkt_seq_q : prev_seq_q;

  always_comb begin
    pkt_type_d  = (pos == 9'd0) ? byte_q : pkt_type_q;
    pkt_seq_d   = (pos == 9'd1) ? byte_q : pkt_seq_q;
    pay_len_d   = (pos == 9'd2) ? byte_q : pay_len_q;
    pos_d       = is_verdict ? 9'd0 : pos + 9'd1;
    exp_seq_d   = exp_seq_q;
    prev_type_d = prev_type_q;
    prev_seq_d  = prev_seq_q;
    finished_d  = finished_q;
    if (is_verdict && acc) begin
      exp_seq_d   = exp_seq_q + 8'd1;
      prev_type_d = ACK_TYPE;
      prev_seq_d  = pkt_seq_q;
      finished_d  = fin;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.payload_byte = byte_q;
    ver_res              = '0;
    ver_res.kind         = 1'b1;
    ver_res.reply_type   = v_type;
    ver_res.reply_seq    = v_seq;
    ver_res.reply_check  = ~eac_add(v_type, v_seq);
    ver_res.accepted     = acc;
    ver_res.deliver      = acc && ((pkt_type_q == DATA_TYPE) || (pkt_type_q == LAST_TYPE));
    ver_res.closed       = fin;
    ver_res.last         = fin;
    wr.push_a = work & (is_payload | is_verdict);
    wr.push_b = work & is_payload & is_verdict;
    wr.data_a = is_payload ? pay_res : ver_res;
    wr.data_b = ver_res;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      sop_q  <= start_of_packet_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      exp_seq_q   <= 8'd0;
      prev_type_q <= NAK_TYPE;
      prev_seq_q  <= INIT_REPLY_SEQ;
      pos_q       <= 9'd0;
      pkt_type_q  <= 8'd0;
      pkt_seq_q   <= 8'd0;
      pay_len_q   <= 8'd0;
      sum_q       <= 8'd0;
      finished_q  <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (work) begin
        exp_seq_q   <= exp_seq_d;
        prev_type_q <= prev_type_d;
        prev_seq_q  <= prev_seq_d;
        pos_q       <= pos_d;
        pkt_type_q  <= pkt_type_d;
        pkt_seq_q   <= pkt_seq_d;
        pay_len_q   <= pay_len_d;
        sum_q       <= sum_d;
        finished_q  <= finished_d;
      end
    end
  end

  gbn_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign out_valid_o    = count != '0;
  assign pop            = out_valid_o & ~out_stall_i;
  assign kind_o         = head.kind;
  assign payload_byte_o = head.payload_byte;
  assign reply_type_o   = head.reply_type;
  assign reply_seq_o    = head.reply_seq;
  assign reply_check_o  = head.reply_check;
  assign accepted_o     = head.accepted;
  assign deliver_o      = head.deliver;
  assign closed_o       = head.closed;
  assign last_o         = head.last;

  `ASSERT_ALWAYS(a_fifo_bound, count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_IMPLIES(a_closed_is_last, out_valid_o && closed_o, last_o && kind_o,
                  "close verdict not marked last")
  `ASSERT_IMPLIES(a_no_push_closed, finished_q, !wr.push_a && !wr.push_b,
                  "result produced after close")
  `ASSERT_NEXT(a_finished_sticks, finished_q, finished_q, "closed state cleared")

endmodule

`default_nettype wire

// ===== tb/gbn_reply_checker.sv =====
// checker for the go-back-n receiver: predicts results from accepted bytes and compares
module gbn_reply_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  wire  [7:0] data_byte_i,
  input  wire        start_of_packet_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  wire        kind_i,
  input  wire  [7:0] payload_byte_i,
  input  wire  [7:0] reply_type_i,
  input  wire  [7:0] reply_seq_i,
  input  wire  [7:0] reply_check_i,
  input  wire        accepted_i,
  input  wire        deliver_i,
  input  wire        closed_i,
  input  wire        last_i,
  output int         mismatches_o,
  output int         pending_o
);
  import gbn_pkg::*;

  result_t    expected_results[$];
  logic [7:0] want_seq = 8'd0;
  logic [7:0] reply_type_q = NAK_TYPE;
  logic [7:0] reply_seq_q = INIT_REPLY_SEQ;
  logic [8:0] pos = 9'd0;
  logic [7:0] pkt_type = 8'd0;
  logic [7:0] pkt_seq = 8'd0;
  logic [7:0] pkt_len = 8'd0;
  logic [7:0] csum = 8'd0;
  logic       shut = 1'b0;
  int         miss_count = 0;

  function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
    int t;
    t = a + b;
    if (t > 255) t -= 255;
    return t[7:0];
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic mark);
    result_t r;
    logic    ok;
    logic    fin;
    if (shut) return;
    if (mark) pos = 9'd0;
    if (pos == 9'd0) begin
      pkt_type = b;
      csum = b;
    end else begin
      csum = ones_add(csum, b);
    end
    if (pos == 9'd1) pkt_seq = b;
    else if (pos == 9'd2) pkt_len = b;
    if (pos >= 9'd4) begin
      r = '0;
      r.payload_byte = b;
      expected_results.push_back(r);
    end
    if (pos >= 9'd3 && pos == {1'b0, pkt_len} + 9'd3) begin
      ok = (csum == 8'hFF) && (pkt_seq == want_seq);
      fin = ok && (pkt_type == FIN_TYPE);
      if (ok) begin
        want_seq = want_seq + 8'd1;
        reply_type_q = ACK_TYPE;
        reply_seq_q = pkt_seq;
      end
      r = '0;
      r.kind = 1'b1;
      r.reply_type = reply_type_q;
      r.reply_seq = reply_seq_q;
      r.reply_check = ~ones_add(reply_type_q, reply_seq_q);
      r.accepted = ok;
      r.deliver = ok && (pkt_type == DATA_TYPE || pkt_type == LAST_TYPE);
      r.closed = fin;
      r.last = fin;
      if (fin) shut = 1'b1;
      expected_results.push_back(r);
      pos = 9'd0;
    end else begin
      pos = pos + 9'd1;
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      miss_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t unexpected result: expected none, actual kind %0d byte %0d reply %0d/%0d",
               $time, kind_i, payload_byte_i, reply_type_i, reply_seq_i);
      miss_count++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", want.kind, kind_i);
    compare_field("payload_byte", want.payload_byte, payload_byte_i);
    compare_field("reply_type", want.reply_type, reply_type_i);
    compare_field("reply_seq", want.reply_seq, reply_seq_i);
    compare_field("reply_check", want.reply_check, reply_check_i);
    compare_field("accepted", want.accepted, accepted_i);
    compare_field("deliver", want.deliver, deliver_i);
    compare_field("closed", want.closed, closed_i);
    compare_field("last", want.last, last_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_seq = 8'd0;
      reply_type_q = NAK_TYPE;
      reply_seq_q = INIT_REPLY_SEQ;
      pos = 9'd0;
      pkt_type = 8'd0;
      pkt_seq = 8'd0;
      pkt_len = 8'd0;
      csum = 8'd0;
      shut = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_byte(data_byte_i, start_of_packet_i);
      if (out_valid_i && !out_stall_i) check_result();
    end
    mismatches_o <= miss_count;
    pending_o <= expected_results.size();
  end

endmodule

// ===== tb/go_back_n_receiver_tb.sv =====
// testbench top: byte stimulus, stall patterns and verdict for the go-back-n receiver
module go_back_n_receiver_tb;
  import gbn_pkg::*;

  localparam int NUM_ITEMS   = 550;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic       start_of_packet = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] reply_type;
  logic [7:0] reply_seq;
  logic [7:0] reply_check;
  logic       accepted;
  logic       deliver;
  logic       closed;
  logic       last;
  int         mismatches;
  int         pending;

  int         cycles = 0;
  int         items_sent = 0;
  logic [7:0] next_seq = 8'd0;
  bit         at_boundary = 1'b1;
  bit         sender_burst = 1'b0;
  bit         receiver_burst = 1'b0;

  go_back_n_receiver u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .start_of_packet_i (start_of_packet),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .kind_o            (kind),
    .payload_byte_o    (payload_byte),
    .reply_type_o      (reply_type),
    .reply_seq_o       (reply_seq),
    .reply_check_o     (reply_check),
    .accepted_o        (accepted),
    .deliver_o         (deliver),
    .closed_o          (closed),
    .last_o            (last)
  );

  gbn_reply_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .data_byte_i       (data_byte),
    .start_of_packet_i (start_of_packet),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .kind_i            (kind),
    .payload_byte_i    (payload_byte),
    .reply_type_i      (reply_type),
    .reply_seq_i       (reply_seq),
    .reply_check_i     (reply_check),
    .accepted_i        (accepted),
    .deliver_i         (deliver),
    .closed_i          (closed),
    .last_i            (last),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout: expected %0d more results, actual none", $time, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ones-complement fold of a plain sum
  function automatic logic [7:0] fold(input int v);
    while (v > 255) v = (v & 255) + (v >> 8);
    return v[7:0];
  endfunction

  function automatic logic [7:0] pick_type(input bit allow_fin);
    logic [7:0] t;
    case ($urandom_range(0, 6))
      0, 1: t = DATA_TYPE;
      2: t = LAST_TYPE;
      3: t = ACK_TYPE;
      4: t = NAK_TYPE;
      5: t = FIN_TYPE;
      default: t = 8'($urandom);
    endcase
    if (t == FIN_TYPE && !allow_fin) t = DATA_TYPE;
    return t;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic mark);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_packet <= mark;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // cut below the full size truncates the packet so the next one restarts it
  task automatic send_packet(input logic [7:0] ptype, input logic [7:0] pseq, input int plen,
                             input bit corrupt, input bit mark, input int cut);
    logic [7:0] pkt[$];
    int         total;
    logic [7:0] chk;
    pkt = '{ptype, pseq, 8'(plen), 8'h00};
    for (int k = 0; k < plen; k++) pkt.push_back(8'($urandom));
    total = 0;
    foreach (pkt[k]) total += pkt[k];
    chk = ~fold(total);
    if (corrupt) begin
      chk = chk ^ 8'($urandom_range(1, 255));
      if (fold(total + chk) == 8'hFF) chk = ~fold(total) + 8'd1;
    end
    pkt[3] = chk;
    foreach (pkt[k]) if (k < cut) send_byte(pkt[k], (k == 0) ? mark : 1'b0);
    if (cut >= pkt.size()) begin
      at_boundary = 1'b1;
      if (fold(total + chk) == 8'hFF && pseq == next_seq) next_seq = next_seq + 8'd1;
    end else begin
      at_boundary = 1'b0;
    end
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 8);
  endfunction

  initial begin
    int         sel;
    int         plen;
    logic [7:0] pseq;
    logic [7:0] b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // initial nak reply, good data, unmarked packet, mid-packet restart, bad checksum
    send_packet(DATA_TYPE, 8'd5, 0, 1'b0, 1'b1, 99);
    send_packet(DATA_TYPE, 8'd0, 1, 1'b0, 1'b1, 99);
    send_packet(LAST_TYPE, 8'd1, 0, 1'b0, 1'b0, 99);
    send_packet(DATA_TYPE, 8'd2, 3, 1'b0, 1'b1, 5);
    send_packet(8'hFF, 8'd2, 1, 1'b1, 1'b1, 99);
    wait_drained();

    while (items_sent < NUM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) sender_burst = !sender_burst;
      sel = $urandom_range(0, 99);
      plen = pick_len();
      if (sel < 60) begin
        send_packet(pick_type(1'b0), next_seq, plen, 1'b0,
                    at_boundary ? 1'($urandom_range(0, 1)) : 1'b1, 999);
      end else if (sel < 70) begin
        pseq = ($urandom_range(0, 1) == 0) ? next_seq - 8'($urandom_range(1, 4))
                                           : 8'($urandom);
        if (pseq == next_seq) pseq = pseq + 8'd1;
        send_packet(pick_type(1'b1), pseq, plen, 1'b0, 1'b1, 999);
      end else if (sel < 78) begin
        send_packet(pick_type(1'b1), next_seq, plen, 1'b1, 1'b1, 999);
      end else if (sel < 88) begin
        send_packet(pick_type(1'b1), next_seq, plen, 1'b0, 1'b1,
                    $urandom_range(1, plen + 3));
      end else if (sel < 96) begin
        repeat ($urandom_range(1, 8)) begin
          b = 8'($urandom);
          if (b == FIN_TYPE) b = ~b;
          send_byte(b, 1'($urandom_range(0, 1)));
        end
        at_boundary = 1'b0;
      end else begin
        wait_drained();
      end
    end

    // closing fin, then bytes that the closed block drops
    send_packet(FIN_TYPE, next_seq, 0, 1'b0, 1'b1, 99);
    repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      hold = receiver_burst ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule
